FILE: sv/rpe_pkg.sv
// Package for the rumble envelope block: widths, fixed-point constants, item kinds.
// No dependencies; imported by rpe_alu, rumble_pwm_envelope and the bench.
`default_nettype none

package rpe_pkg;

    // Fractional bits of level, accumulator and fade
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int KIND_W = 2;
    localparam int LVL_W  = FRAC_BITS + 1;   // level, strength, accumulator
    localparam int DUR_W  = 16;              // duration Q8.8
    localparam int TS_W   = 16;              // time step
    localparam int FADE_W = FRAC_BITS + 5;   // fade rate Q5.F
    localparam int DVD_W  = LVL_W + 8;       // dividend: capped strength << 8
    localparam int DEC_W  = FADE_W + TS_W - FRAC_BITS;
    localparam int ALU_W  = (FADE_W + 1 > DEC_W + 1) ? FADE_W + 1 : DEC_W + 1;
    localparam int STEP_N = (DVD_W > TS_W) ? DVD_W : TS_W;
    localparam int CNT_W  = $clog2(STEP_N + 1);

    // Fixed-point constants
    localparam logic [LVL_W-1:0] ONE_LEVEL = LVL_W'(1) << FRAC_BITS;
    localparam logic [LVL_W-1:0] LOW_LEVEL = LVL_W'((64'd1 << FRAC_BITS) / 100);
    localparam logic [DUR_W-1:0] MIN_DUR   = DUR_W'(13);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KICK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ENABLE = 2'd2;

endpackage

`default_nettype wire

FILE: sv/rpe_alu.sv
// Shared adder/subtractor for the rumble envelope sequencer.
// Depends on rpe_pkg for the datapath width.
`default_nettype none

module rpe_alu (
    input  wire logic [rpe_pkg::ALU_W-1:0] a,
    input  wire logic [rpe_pkg::ALU_W-1:0] b,
    input  wire logic                      sub,
    output logic      [rpe_pkg::ALU_W-1:0] result,
    output logic                           carry
);
    import rpe_pkg::*;

    logic [ALU_W:0] full;

    // Add, or subtract in two's complement; carry high on subtract means no borrow
    always_comb
    begin
        full   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ALU_W{1'b0}}, sub};
        result = full[ALU_W-1:0];
        carry  = full[ALU_W];
    end

endmodule

`default_nettype wire

FILE: sv/rumble_pwm_envelope.sv
// Rumble motor driver: linear decay envelope followed by a Bresenham PWM stage.
// Depends on rpe_pkg and on rpe_alu, the one adder shared by every step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: kind selects tick,
//   kick or set enable; the other fields are read as that kind needs them.
//   Output channel (out_valid/out_ready) returns one result per request:
//   motor_state after the request and drive_write, a pulse that tells the
//   host to write the motor when the state changed on a pak-equipped tick.
//   Steps, request accepted to result valid:
//     tick        serial shift-add multiply, subtract,
//                 accumulate, all through the shared adder
//     kick        when it loads: restoring divider,
//                 one quotient bit per cycle on the shared adder; none otherwise
//     set enable  no work; straight to the done state
//   One request is in work at a time; in_ready is high only while idle, so a
//   new request is taken only once the previous one has left the sequencer.
//   If the receiver stalls, the finished request waits in the sequencer and
//   the output register holds the earlier result; the next request may be taken
//   while a result is still waiting.
//   Reset clears level, fade, accumulator and motor, sets enabled, and
//   leaves the block idle with no result pending.
`default_nettype none

module rumble_pwm_envelope (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [rpe_pkg::KIND_W-1:0]  kind,
    input  wire logic [rpe_pkg::LVL_W-1:0]   strength,
    input  wire logic [rpe_pkg::DUR_W-1:0]   duration,
    input  wire logic [rpe_pkg::TS_W-1:0]    time_step,
    input  wire logic                        enable_value,
    input  wire logic                        pak_present,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             motor_state,
    output logic                             drive_write
);
    import rpe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_TSUB,
        S_TACC,
        S_DIV,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [FADE_W-1:0] fade_reg, fade_next;
    logic [LVL_W-1:0]  acc_reg, acc_next;
    logic              motor_reg, motor_next;
    logic              enabled_reg, enabled_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FADE_W-1:0] hi_reg, hi_next;        // product high half
    logic [TS_W-1:0]   lo_reg, lo_next;        // multiplier, then product low half
    logic [DVD_W-1:0]  quo_reg, quo_next;      // dividend, then quotient
    logic [DUR_W:0]    rem_reg, rem_next;
    logic [DUR_W-1:0]  dvs_reg, dvs_next;
    logic              pak_reg, pak_next;
    logic              drive_reg, drive_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_motor_reg, out_motor_next;
    logic              out_drive_reg, out_drive_next;

    logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
    logic              alu_sub, alu_carry;

    logic [LVL_W-1:0]  capped;
    logic [DUR_W:0]    rem_shift;
    logic [FADE_W+TS_W-1:0] product;
    logic [DEC_W-1:0]  dec;
    logic              want;

    rpe_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .result (alu_res),
        .carry  (alu_carry)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign motor_state = out_motor_reg;
    assign drive_write = out_drive_reg;

    // Steer the shared adder by sequencer step
    always_comb
    begin
        capped    = (strength > ONE_LEVEL) ? ONE_LEVEL : strength;
        rem_shift = {rem_reg[DUR_W-1:0], quo_reg[DVD_W-1]};
        product   = {hi_reg, lo_reg};
        dec       = DEC_W'(product >> FRAC_BITS);
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        unique case (state_reg)
            S_MUL:
            begin
                alu_a = ALU_W'(hi_reg);
                alu_b = lo_reg[0] ? ALU_W'(fade_reg) : '0;
            end
            S_TSUB:
            begin
                alu_a   = ALU_W'(level_reg);
                alu_b   = ALU_W'(dec);
                alu_sub = 1'b1;
            end
            S_TACC:
            begin
                alu_a = ALU_W'(acc_reg);
                alu_b = ALU_W'(level_reg);
            end
            S_DIV:
            begin
                alu_a   = ALU_W'(rem_shift);
                alu_b   = ALU_W'(dvs_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // Sequencer next-state and datapath
    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        fade_next      = fade_reg;
        acc_next       = acc_reg;
        motor_next     = motor_reg;
        enabled_next   = enabled_reg;
        cnt_next       = cnt_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        pak_next       = pak_reg;
        drive_next     = drive_reg;
        out_valid_next = out_valid_reg;
        out_motor_next = out_motor_reg;
        out_drive_next = out_drive_reg;
        want           = 1'b0;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    drive_next = 1'b0;
                    state_next = S_DONE;
                    priority if (kind == KIND_TICK)
                    begin
                        hi_next    = '0;
                        lo_next    = time_step;
                        pak_next   = pak_present;
                        cnt_next   = CNT_W'(TS_W);
                        state_next = S_MUL;
                    end
                    else if (kind == KIND_KICK)
                    begin
                        if (enabled_reg && (strength > level_reg))
                        begin
                            level_next = capped;
                            quo_next   = {capped, 8'd0};
                            rem_next   = '0;
                            dvs_next   = (duration < MIN_DUR) ? MIN_DUR : duration;
                            cnt_next   = CNT_W'(DVD_W);
                            state_next = S_DIV;
                        end
                    end
                    else if (kind == KIND_ENABLE)
                    begin
                        enabled_next = enable_value;
                        if (!enable_value)
                        begin
                            level_next = '0;
                            fade_next  = '0;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MUL:
            begin
                // Add fade on a set multiplier bit, then shift product right
                hi_next  = alu_res[FADE_W:1];
                lo_next  = {alu_res[0], lo_reg[TS_W-1:1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_TSUB;
                end
            end
            S_TSUB:
            begin
                // Decay the level, saturating at zero on borrow
                level_next = alu_carry ? alu_res[LVL_W-1:0] : '0;
                state_next = S_TACC;
            end
            S_TACC:
            begin
                if (level_reg <= LOW_LEVEL)
                begin
                    acc_next = '0;
                    want     = 1'b0;
                end
                else
                begin
                    // Sum stays below two, so bit F is the overflow
                    want     = alu_res[FRAC_BITS];
                    acc_next = {1'b0, alu_res[FRAC_BITS-1:0]};
                end
                if (want != motor_reg)
                begin
                    motor_next = want;
                    drive_next = pak_reg;
                end
                state_next = S_DONE;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per step
                if (alu_carry)
                begin
                    rem_next = alu_res[DUR_W:0];
                end
                else
                begin
                    rem_next = rem_shift;
                end
                quo_next = {quo_reg[DVD_W-2:0], alu_carry};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_motor_next = motor_reg;
                    out_drive_next = drive_reg;
                    state_next     = S_IDLE;
                end
                if (cnt_reg == '0 && quo_reg != '0)
                begin
                    fade_next = fade_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load fade when the divider finishes
        if (state_reg == S_DIV && cnt_reg == CNT_W'(1))
        begin
            fade_next = FADE_W'({quo_reg[DVD_W-2:0], alu_carry});
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            fade_reg      <= '0;
            acc_reg       <= '0;
            motor_reg     <= 1'b0;
            enabled_reg   <= 1'b1;
            cnt_reg       <= '0;
            drive_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_motor_reg <= 1'b0;
            out_drive_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            fade_reg      <= fade_next;
            acc_reg       <= acc_next;
            motor_reg     <= motor_next;
            enabled_reg   <= enabled_next;
            cnt_reg       <= cnt_next;
            drive_reg     <= drive_next;
            out_valid_reg <= out_valid_next;
            out_motor_reg <= out_motor_next;
            out_drive_reg <= out_drive_next;
        end
    end

    // Working registers of the shared unit
    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        pak_reg <= pak_next;
    end

endmodule

`default_nettype wire

FILE: tb/tb_rumble_pwm_envelope.sv
// Self-checking bench for rumble_pwm_envelope: directed kick/tick/enable cases,
// then random decay bursts with random stalls on both sides.
// Depends on rpe_pkg and the rumble_pwm_envelope RTL.
`default_nettype none

module tb_rumble_pwm_envelope;
    timeunit 1ns;
    timeprecision 1ps;

    import rpe_pkg::*;

    // kind code that the block leaves without effect
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic motor;
        logic drive;
    } motor_result_t;

    // Envelope and PWM predictor plus the queue of motor results still owed
    class motor_predictor;
        logic [LVL_W-1:0]  level;
        logic [FADE_W-1:0] fade;
        logic [LVL_W-1:0]  pwm_acc;
        logic              motor;
        logic              enabled;
        motor_result_t     owed[$];
        int                errors;

        function new();
            level   = '0;
            fade    = '0;
            pwm_acc = '0;
            motor   = 1'b0;
            enabled = 1'b1;
            errors  = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Advance the envelope by one accepted request and queue its result
        function void take_request(logic [KIND_W-1:0] k, logic [LVL_W-1:0] s,
                                   logic [DUR_W-1:0] d, logic [TS_W-1:0] dt,
                                   logic en, logic pak);
            motor_result_t            r;
            logic [FADE_W+TS_W-1:0]   prod;
            logic [FADE_W-1:0]        dec;
            logic [LVL_W:0]           sum;
            logic [LVL_W-1:0]         cap;
            logic [DUR_W-1:0]         dur;
            logic                     want;
            r.drive = 1'b0;
            case (k)
                KIND_TICK:
                begin
                    prod  = fade * dt;
                    dec   = prod[FADE_W+TS_W-1:FRAC_BITS];
                    level = (level > dec) ? level - dec : '0;
                    if (level <= LOW_LEVEL)
                    begin
                        pwm_acc = '0;
                        want    = 1'b0;
                    end
                    else
                    begin
                        sum  = pwm_acc + level;
                        want = (sum >= ONE_LEVEL);
                        if (want)
                            sum = sum - ONE_LEVEL;
                        pwm_acc = sum[LVL_W-1:0];
                    end
                    if (want != motor)
                    begin
                        motor   = want;
                        r.drive = pak;
                    end
                end
                KIND_KICK:
                begin
                    if (enabled && s > level)
                    begin
                        cap   = (s > ONE_LEVEL) ? ONE_LEVEL : s;
                        dur   = (d < MIN_DUR) ? MIN_DUR : d;
                        level = cap;
                        fade  = {cap, 8'd0} / dur;
                    end
                end
                KIND_ENABLE:
                begin
                    enabled = en;
                    if (!en)
                    begin
                        level = '0;
                        fade  = '0;
                    end
                end
                default:
                begin
                end
            endcase
            r.motor = motor;
            owed.push_back(r);
        endfunction

        // Compare one delivered result against the oldest owed one
        function void check_motor(logic m, logic dw);
            motor_result_t e;
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t: result with none owed: motor_state=%0b drive_write=%0b",
                         $time, m, dw);
                return;
            end
            e = owed.pop_front();
            if (m !== e.motor)
            begin
                errors++;
                if (errors <= 100)
                    $display("%0t: motor_state expected %0b got %0b", $time, e.motor, m);
            end
            if (dw !== e.drive)
            begin
                errors++;
                if (errors <= 100)
                    $display("%0t: drive_write expected %0b got %0b", $time, e.drive, dw);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [KIND_W-1:0]  kind = KIND_TICK;
    logic [LVL_W-1:0]   strength = '0;
    logic [DUR_W-1:0]   duration = '0;
    logic [TS_W-1:0]    time_step = '0;
    logic               enable_value = 1'b0;
    logic               pak_present = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               motor_state;
    logic               drive_write;

    int                 sent = 0;
    logic               calm = 1'b0;
    motor_predictor     sb = new();

    rumble_pwm_envelope dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .strength     (strength),
        .duration     (duration),
        .time_step    (time_step),
        .enable_value (enable_value),
        .pak_present  (pak_present),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .motor_state  (motor_state),
        .drive_write  (drive_write)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the result side at random, except in the calm stretch
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 17);

    // Check delivered results, then note accepted requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_motor(motor_state, drive_write);
            if (in_valid && in_ready)
                sb.take_request(kind, strength, duration, time_step,
                                enable_value, pak_present);
        end
    end

    // Present one request and hold it until accepted
    task automatic send_request(logic [KIND_W-1:0] k, logic [LVL_W-1:0] s,
                                logic [DUR_W-1:0] d, logic [TS_W-1:0] dt,
                                logic en, logic pak);
        while (!calm && $urandom_range(0, 99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        strength     <= s;
        duration     <= d;
        time_step    <= dt;
        enable_value <= en;
        pak_present  <= pak;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        calm = (sent >= 600 && sent < 900);
    endtask

    // Fields a kind does not use are filled with noise
    task automatic send_tick(logic [TS_W-1:0] dt, logic pak);
        send_request(KIND_TICK, LVL_W'($urandom), DUR_W'($urandom), dt,
                     1'($urandom), pak);
    endtask

    task automatic send_kick(logic [LVL_W-1:0] s, logic [DUR_W-1:0] d);
        send_request(KIND_KICK, s, d, TS_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_enable(logic en);
        send_request(KIND_ENABLE, LVL_W'($urandom), DUR_W'($urandom),
                     TS_W'($urandom), en, 1'($urandom));
    endtask

    function automatic logic [LVL_W-1:0] rand_strength();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return LVL_W'($urandom_range(700, 65536));
        else if (p < 85)
            return LVL_W'($urandom_range(0, 131071));
        return LVL_W'($urandom_range(0, 1000));
    endfunction

    function automatic logic [DUR_W-1:0] rand_duration();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return DUR_W'($urandom_range(13, 1024));
        else if (p < 80)
            return DUR_W'($urandom_range(0, 20));
        return DUR_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [TS_W-1:0] rand_step();
        if ($urandom_range(0, 9) == 0)
            return TS_W'($urandom_range(0, 65535));
        return TS_W'($urandom_range(0, 2200));
    endfunction

    initial
    begin
        int pick;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle envelope, spare kind, zero kick
        send_tick(16'd0, 1'b1);
        send_request(KIND_SPARE, '1, '1, '1, 1'b1, 1'b1);
        send_kick(17'd0, 16'd0);
        // full-scale kick with zero duration: cap strength, raise duration
        send_kick(17'd131071, 16'd0);
        send_tick(16'd0, 1'b1);
        send_tick(16'd0, 1'b0);
        // equal strength does not reload
        send_kick(17'd65536, 16'd65535);
        // longest step drains the level to zero
        send_tick(16'd65535, 1'b1);
        send_kick(17'd65535, 16'd12);
        // disable clears; kicks ignored while off; ticks still run
        send_enable(1'b0);
        send_kick(17'd65536, 16'd13);
        send_tick(16'd1, 1'b1);
        send_enable(1'b1);
        // level just above the low threshold, then a weaker kick
        send_kick(17'd700, 16'd65535);
        send_tick(16'd0, 1'b1);
        send_kick(17'd656, 16'd100);
        send_tick(16'd0, 1'b1);
        send_kick(17'd65537, 16'd256);
        send_tick(16'd1092, 1'b1);
        send_tick(16'd1092, 1'b0);
        send_tick(16'd1092, 1'b1);
        // disable with the motor running; the motor drops on the next tick
        send_kick(17'd131071, 16'd65535);
        send_tick(16'd0, 1'b1);
        send_enable(1'b0);
        send_tick(16'd500, 1'b0);
        send_enable(1'b1);

        // random decay bursts with some noise and enable toggling
        while (sent < 1525)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                send_enable(1'b0);
                n = $urandom_range(0, 3);
                repeat (n) send_tick(rand_step(), 1'($urandom));
                send_kick(rand_strength(), rand_duration());
                send_enable(1'b1);
            end
            else if (pick < 6)
                send_enable(1'b1);
            else if (pick < 8)
                send_request(KIND_SPARE, LVL_W'($urandom), DUR_W'($urandom),
                             TS_W'($urandom), 1'($urandom), 1'($urandom));
            else if (pick < 12)
            begin
                send_request(KIND_W'($urandom_range(0, 3)), LVL_W'($urandom),
                             DUR_W'($urandom), TS_W'($urandom), 1'($urandom),
                             1'($urandom));
                send_enable(1'b1);
            end
            else
            begin
                send_kick(rand_strength(), rand_duration());
                n = $urandom_range(4, 40);
                repeat (n) send_tick(rand_step(), ($urandom_range(0, 9) != 0));
            end
        end
        in_valid <= 1'b0;

        // drain owed results, then let any stray result show up
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Hard stop if the handshake hangs
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

FILE: rumble_pwm_envelope.f
sv/rpe_pkg.sv
sv/rpe_alu.sv
sv/rumble_pwm_envelope.sv
tb/tb_rumble_pwm_envelope.sv
